// ===== sv/compare_capture_timer_core_defines.svh =====
// Assertion helpers used by the checker file of this block.
`ifndef COMPARE_CAPTURE_TIMER_CORE_DEFINES_SVH
`define COMPARE_CAPTURE_TIMER_CORE_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define CCT_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("compare_capture_timer_core: same-cycle check failed");

// The consequent holds in the cycle after the antecedent.
`define CCT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("compare_capture_timer_core: next-cycle check failed");

`define CCT_ASSERT_LAT2(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
    else $error("compare_capture_timer_core: latency check failed");

`endif

// ===== sv/cct_pkg.sv =====
package cct_pkg;

  // Task and access codes carried in the kind field.
  localparam logic [3:0] KIND_TICK          = 4'd0;
  localparam logic [3:0] KIND_START         = 4'd1;
  localparam logic [3:0] KIND_STOP          = 4'd2;
  localparam logic [3:0] KIND_COUNT         = 4'd3;
  localparam logic [3:0] KIND_CLEAR         = 4'd4;
  localparam logic [3:0] KIND_CAPTURE       = 4'd5;
  localparam logic [3:0] KIND_CLEAR_EVENT   = 4'd6;
  localparam logic [3:0] KIND_WRITE_COMPARE = 4'd7;
  localparam logic [3:0] KIND_READ_COMPARE  = 4'd8;
  localparam logic [3:0] KIND_READ_EVENT    = 4'd9;

  // Configuration register indexes.
  localparam logic [2:0] REG_COUNTER_MODE     = 3'd0;
  localparam logic [2:0] REG_WIDTH_SELECT     = 3'd1;
  localparam logic [2:0] REG_PRESCALE_SHIFT   = 3'd2;
  localparam logic [2:0] REG_CLEAR_ON_COMPARE = 3'd3;
  localparam logic [2:0] REG_STOP_ON_COMPARE  = 3'd4;
  localparam logic [2:0] REG_IRQ_ENABLE       = 3'd5;

  // Width select codes.
  localparam logic [1:0] WIDTH_16 = 2'd0;
  localparam logic [1:0] WIDTH_8  = 2'd1;
  localparam logic [1:0] WIDTH_24 = 2'd2;
  localparam logic [1:0] WIDTH_32 = 2'd3;

  // Packed stream widths.
  localparam int IN_TDATA_W  = 40;
  localparam int IN_TUSER_W  = 4;
  localparam int OUT_TDATA_W = 72;

  typedef logic [31:0] word_t;

  // Counter wrap mask for a width select code.
  function automatic word_t width_mask(input logic [1:0] sel);
    word_t m;
    case (sel)
      WIDTH_16: m = 32'h0000_FFFF;
      WIDTH_8:  m = 32'h0000_00FF;
      WIDTH_24: m = 32'h00FF_FFFF;
      WIDTH_32: m = 32'hFFFF_FFFF;
      default:  m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  // Per-channel register bit; channels above 3 have no bit and read as 0.
  function automatic logic reg_bit(input logic [3:0] r, input int i);
    logic b;
    b = 1'b0;
    if (i < 4) begin
      b = r[i[1:0]];
    end
    return b;
  endfunction

endpackage

// ===== sv/compare_capture_timer_core.sv =====
// Path: an accepted beat goes into the input register and, once the output register is free or
// being taken, through the state update into the output register. Throughput: one beat per cycle
// while the output is not stalled; while a result waits the input register takes one more beat.
// Reset: synchronous, active high; clears the counter, prescaler, compare values,
// event flags, run state and all configuration registers.
module compare_capture_timer_core
  import cct_pkg::*;
#(
  parameter int CHANNELS = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  // Input stream.
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // channel[1:0], write_value[33:2], zero pad
  input  logic [IN_TUSER_W-1:0]  s_tuser,   // kind[3:0]
  // Result stream.
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // irq[0], read_data[32:1], event_flags[36:33],
                                            // count_value[68:37], zero pad
  // Configuration write channel.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [2:0]             cfg_index,
  input  logic [31:0]            cfg_data
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Configuration registers.
  logic       counter_mode;
  logic [1:0] width_select;
  logic [3:0] prescale_shift;
  logic [3:0] clear_on_compare;
  logic [3:0] stop_on_compare;
  logic [3:0] irq_enable;

  // Timer state.
  word_t               count;
  word_t               compare_value [CHANNELS];
  logic [CHANNELS-1:0] event_flag;
  logic                is_running;
  logic [14:0]         prescale_count;

  word_t               count_next;
  word_t               compare_next [CHANNELS];
  logic [CHANNELS-1:0] event_next;
  logic                running_next;
  logic [14:0]         prescale_next;

  // Input register.
  logic       in_valid;
  logic [3:0] in_kind;
  logic [1:0] in_channel;
  word_t      in_value;

  // Output register.
  logic       out_valid;
  logic       out_irq;
  word_t      out_read;
  logic [3:0] out_events;
  word_t      out_count;

  logic       advance;
  logic       ch_ok;
  logic [CH_W-1:0] ch_idx;
  word_t      mask;
  word_t      step_count;
  logic [CHANNELS-1:0] match;
  logic       step_clear;
  logic       step_stop;
  logic [14:0] limit;
  logic       do_step;
  word_t      read_next;
  logic [3:0] events_view;
  logic       irq_next;

  assign cfg_ready = 1'b1;
  assign advance   = in_valid && (!out_valid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign m_tvalid  = out_valid;
  assign m_tdata   = {3'b000, out_count, out_events, out_read, out_irq};

  // Configuration writes; indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      counter_mode     <= 1'b0;
      width_select     <= 2'd0;
      prescale_shift   <= 4'd0;
      clear_on_compare <= 4'd0;
      stop_on_compare  <= 4'd0;
      irq_enable       <= 4'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_COUNTER_MODE:     counter_mode     <= cfg_data[0];
        REG_WIDTH_SELECT:     width_select     <= cfg_data[1:0];
        REG_PRESCALE_SHIFT:   prescale_shift   <= cfg_data[3:0];
        REG_CLEAR_ON_COMPARE: clear_on_compare <= cfg_data[3:0];
        REG_STOP_ON_COMPARE:  stop_on_compare  <= cfg_data[3:0];
        REG_IRQ_ENABLE:       irq_enable       <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Input register takes a beat whenever it is empty or moving on.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_kind    <= s_tuser[3:0];
      in_channel <= s_tdata[1:0];
      in_value   <= s_tdata[33:2];
    end
  end

  // Counter step: wrap, compare against every channel, gather clear and stop.
  always_comb begin
    mask       = width_mask(width_select);
    step_count = (count + 32'd1) & mask;
    step_clear = 1'b0;
    step_stop  = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      match[i] = (compare_value[i] == step_count);
      if (match[i] && reg_bit(clear_on_compare, i)) step_clear = 1'b1;
      if (match[i] && reg_bit(stop_on_compare, i))  step_stop  = 1'b1;
    end
  end

  assign limit  = 15'((16'd1 << prescale_shift) - 16'd1);
  assign ch_ok  = (32'(in_channel) < 32'(CHANNELS));
  assign ch_idx = CH_W'(in_channel);

  // Next state for the item held in the input register.
  always_comb begin
    count_next    = count;
    event_next    = event_flag;
    running_next  = is_running;
    prescale_next = prescale_count;
    read_next     = 32'd0;
    do_step       = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      compare_next[i] = compare_value[i];
    end

    case (in_kind)
      KIND_TICK: begin
        if (!counter_mode && is_running) begin
          if (prescale_count >= limit) begin
            prescale_next = 15'd0;
            do_step       = 1'b1;
          end else begin
            prescale_next = prescale_count + 15'd1;
          end
        end
      end
      KIND_START: begin
        if (in_value == 32'd1 && !counter_mode) begin
          running_next  = 1'b1;
          prescale_next = 15'd0;
        end
      end
      KIND_STOP: begin
        if (in_value == 32'd1) running_next = 1'b0;
      end
      KIND_COUNT: begin
        if (in_value == 32'd1 && counter_mode) do_step = 1'b1;
      end
      KIND_CLEAR: begin
        if (in_value == 32'd1) begin
          count_next    = 32'd0;
          prescale_next = 15'd0;
        end
      end
      KIND_CAPTURE: begin
        if (in_value == 32'd1 && ch_ok) compare_next[ch_idx] = count;
      end
      KIND_CLEAR_EVENT: begin
        if (in_value == 32'd0 && ch_ok) event_next[ch_idx] = 1'b0;
      end
      KIND_WRITE_COMPARE: begin
        if (ch_ok) compare_next[ch_idx] = in_value & mask;
      end
      KIND_READ_COMPARE: begin
        if (ch_ok) read_next = compare_value[ch_idx];
      end
      KIND_READ_EVENT: begin
        if (ch_ok) read_next = {31'd0, event_flag[ch_idx]};
      end
      default: ;
    endcase

    // Apply a counter step on top of the task.
    if (do_step) begin
      count_next = step_clear ? 32'd0 : step_count;
      event_next = event_flag | match;
      if (step_clear) prescale_next = 15'd0;
      if (step_stop && !counter_mode) running_next = 1'b0;
    end
  end

  // Event view on the output and the interrupt level.
  always_comb begin
    events_view = 4'd0;
    for (int i = 0; i < 4; i++) begin
      if (i < CHANNELS) events_view[i] = event_next[i];
    end
    irq_next = |(events_view & irq_enable);
  end

  // State registers move with the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      count          <= 32'd0;
      event_flag     <= '0;
      is_running     <= 1'b0;
      prescale_count <= 15'd0;
      for (int i = 0; i < CHANNELS; i++) begin
        compare_value[i] <= 32'd0;
      end
    end else if (advance) begin
      count          <= count_next;
      event_flag     <= event_next;
      is_running     <= running_next;
      prescale_count <= prescale_next;
      for (int i = 0; i < CHANNELS; i++) begin
        compare_value[i] <= compare_next[i];
      end
    end
  end

  // Output register holds a result beat until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_irq    <= irq_next;
      out_read   <= read_next;
      out_events <= events_view;
      out_count  <= count_next;
    end
  end

endmodule

// ===== sv/cct_checker.sv =====
`include "compare_capture_timer_core_defines.svh"

module cct_checker
  import cct_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  // A stalled result beat keeps its payload.
  `CCT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // An empty output register never blocks the input side.
  `CCT_ASSERT_SAME(a_ready_when_empty, !m_tvalid, s_tready)

  // The interrupt line only rises on a pending event flag.
  `CCT_ASSERT_SAME(a_irq_has_event, m_tvalid && m_tdata[0], m_tdata[36:33] != 4'd0)

  // An accepted beat finds a result waiting once it has moved through the input register.
  `CCT_ASSERT_LAT2(a_latency, s_tvalid && s_tready, m_tvalid)

endmodule

bind compare_capture_timer_core cct_checker u_cct_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import cct_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned HOLD_AFTER_BEATS = 400;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned MAX_PRINTED = 40;

  localparam logic MODE_TIMER   = 1'b0;
  localparam logic MODE_COUNTER = 1'b1;

  // Highest code the kind field can carry; codes above read event do nothing.
  localparam logic [3:0] KIND_TOP = 4'hF;

  // Wrap masks in width select order.
  localparam word_t WRAP_MASK [4] = '{32'h0000_FFFF, 32'h0000_00FF,
                                      32'h00FF_FFFF, 32'hFFFF_FFFF};

  typedef struct {
    logic [3:0] kind;
    logic [1:0] ch;
    word_t      wv;
  } beat_t;

  typedef struct {
    logic       irq;
    word_t      rd;
    logic [3:0] ev;
    word_t      cnt;
  } timer_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;   // channel[1:0], write_value[33:2], zero pad
  logic [IN_TUSER_W-1:0]  s_tuser = '0;   // kind[3:0]
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;        // irq[0], read_data[32:1], event_flags[36:33],
                                          // count_value[68:37], zero pad
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [2:0]             cfg_index = '0;
  logic [31:0]            cfg_data = '0;

  compare_capture_timer_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Clock: 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted timer state and its configuration copy.
  word_t       cnt_q;
  word_t       cmp_q [4];
  logic [3:0]  evt_q;
  logic        running_q;
  logic [14:0] presc_q;
  logic        mode_r;
  logic [1:0]  wsel_r;
  logic [3:0]  shift_r, clr_r, stop_r, ien_r;

  beat_t         stim_q [$];
  timer_result_t timer_results_q [$];
  int unsigned   errors = 0;
  int unsigned   beats_taken = 0;
  int unsigned   cycle_count = 0;

  task automatic report_mismatch(input string msg);
    if (errors < MAX_PRINTED) begin
      $display("[%0t] %s", $time, msg);
    end
    errors++;
  endtask

  // One counter step: wrap, compare against every channel, then clear or stop.
  function automatic void advance_count();
    logic hit_clear;
    logic hit_stop;
    hit_clear = 1'b0;
    hit_stop  = 1'b0;
    cnt_q = (cnt_q + 32'd1) & WRAP_MASK[wsel_r];
    for (int i = 0; i < 4; i++) begin
      if (cmp_q[i] == cnt_q) begin
        evt_q[i] = 1'b1;
        if (clr_r[i]) hit_clear = 1'b1;
        if (stop_r[i]) hit_stop = 1'b1;
      end
    end
    if (hit_clear) begin
      cnt_q   = '0;
      presc_q = '0;
    end
    if (hit_stop && mode_r == MODE_TIMER) begin
      running_q = 1'b0;
    end
  endfunction

  // Applies one beat to the predicted state and returns the result it causes.
  function automatic timer_result_t timer_predict(input beat_t b);
    timer_result_t r;
    r.rd = '0;
    case (b.kind)
      KIND_TICK: begin
        if (mode_r == MODE_TIMER && running_q) begin
          if (32'(presc_q) >= (32'd1 << shift_r) - 32'd1) begin
            presc_q = '0;
            advance_count();
          end else begin
            presc_q = presc_q + 15'd1;
          end
        end
      end
      KIND_START: begin
        if (b.wv == 32'd1 && mode_r == MODE_TIMER) begin
          running_q = 1'b1;
          presc_q   = '0;
        end
      end
      KIND_STOP: begin
        if (b.wv == 32'd1) running_q = 1'b0;
      end
      KIND_COUNT: begin
        if (b.wv == 32'd1 && mode_r == MODE_COUNTER) advance_count();
      end
      KIND_CLEAR: begin
        if (b.wv == 32'd1) begin
          cnt_q   = '0;
          presc_q = '0;
        end
      end
      KIND_CAPTURE: begin
        if (b.wv == 32'd1) cmp_q[b.ch] = cnt_q;
      end
      KIND_CLEAR_EVENT: begin
        if (b.wv == 32'd0) evt_q[b.ch] = 1'b0;
      end
      KIND_WRITE_COMPARE: begin
        cmp_q[b.ch] = b.wv & WRAP_MASK[wsel_r];
      end
      KIND_READ_COMPARE: begin
        r.rd = cmp_q[b.ch];
      end
      KIND_READ_EVENT: begin
        r.rd = {31'd0, evt_q[b.ch]};
      end
      default: begin
      end
    endcase
    r.ev  = evt_q;
    r.irq = |(evt_q & ien_r);
    r.cnt = cnt_q;
    return r;
  endfunction

  // Input driver: bursts of beats with random gaps; predicts each accepted beat.
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    beat_t b;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        b.kind = s_tuser;
        b.ch   = s_tdata[1:0];
        b.wv   = s_tdata[33:2];
        timer_results_q.push_back(timer_predict(b));
        beats_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left != 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (stim_q.size() != 0) begin
          b = stim_q.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= b.kind;
          s_tdata  <= {6'd0, b.wv, b.ch};
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result ready: random stall patterns that change from one span to the next,
  // plus one long hold-off while the sender keeps offering beats.
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned stall_span = 0;
  int unsigned stall_mode = 0;

  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (!hold_done && beats_taken >= HOLD_AFTER_BEATS) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      if (stall_span == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_span = $urandom_range(16, 80);
      end
      stall_span--;
      case (stall_mode)
        0:       m_tready <= 1'b1;
        1:       m_tready <= ($urandom_range(0, 1) == 0);
        default: m_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Result monitor: compare each accepted beat with the oldest prediction.
  always @(posedge clk) begin
    timer_result_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (timer_results_q.size() == 0) begin
        report_mismatch("result beat with no prediction pending");
      end else begin
        e = timer_results_q.pop_front();
        if (m_tdata[0] !== e.irq) begin
          report_mismatch($sformatf("irq %b, predicted %b", m_tdata[0], e.irq));
        end
        if (m_tdata[32:1] !== e.rd) begin
          report_mismatch($sformatf("read_data %h, predicted %h", m_tdata[32:1], e.rd));
        end
        if (m_tdata[36:33] !== e.ev) begin
          report_mismatch($sformatf("event_flags %b, predicted %b", m_tdata[36:33], e.ev));
        end
        if (m_tdata[68:37] !== e.cnt) begin
          report_mismatch($sformatf("count_value %h, predicted %h", m_tdata[68:37], e.cnt));
        end
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Waits until every beat has been sent and every predicted result has arrived.
  task automatic wait_drained();
    do @(negedge clk);
    while (stim_q.size() != 0 || s_tvalid || timer_results_q.size() != 0);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [3:0] value);
    word_t keep;
    case (idx)
      REG_COUNTER_MODE: keep = 32'h1;
      REG_WIDTH_SELECT: keep = 32'h3;
      default:          keep = 32'hF;
    endcase
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= (32'(value) & keep) | ($urandom & ~keep);
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_COUNTER_MODE:     mode_r  = value[0];
      REG_WIDTH_SELECT:     wsel_r  = value[1:0];
      REG_PRESCALE_SHIFT:   shift_r = value;
      REG_CLEAR_ON_COMPARE: clr_r   = value;
      REG_STOP_ON_COMPARE:  stop_r  = value;
      REG_IRQ_ENABLE:       ien_r   = value;
      default: begin
      end
    endcase
  endtask

  task automatic push_beat(input logic [3:0] kind, input logic [1:0] ch, input word_t wv);
    beat_t b;
    b.kind = kind;
    b.ch   = ch;
    b.wv   = wv;
    stim_q.push_back(b);
  endtask

  // Random beat; step-heavy phases are mostly ticks or count tasks so the
  // counter travels far enough to match and wrap.
  function automatic beat_t random_beat(input bit step_heavy, input logic mode);
    beat_t b;
    int unsigned roll;
    b.ch = 2'($urandom_range(0, 3));
    b.wv = $urandom;
    roll = $urandom_range(0, 99);
    if (step_heavy && roll < 85) begin
      b.kind = (mode == MODE_COUNTER) ? KIND_COUNT : KIND_TICK;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 35)      b.kind = KIND_TICK;
      else if (roll < 50) b.kind = KIND_COUNT;
      else if (roll < 56) b.kind = KIND_START;
      else if (roll < 60) b.kind = KIND_STOP;
      else if (roll < 64) b.kind = KIND_CLEAR;
      else if (roll < 70) b.kind = KIND_CAPTURE;
      else if (roll < 78) b.kind = KIND_CLEAR_EVENT;
      else if (roll < 87) b.kind = KIND_WRITE_COMPARE;
      else if (roll < 92) b.kind = KIND_READ_COMPARE;
      else if (roll < 97) b.kind = KIND_READ_EVENT;
      else                b.kind = 4'($urandom_range(KIND_READ_EVENT + 1, KIND_TOP));
    end
    roll = $urandom_range(0, 99);
    case (b.kind)
      KIND_START, KIND_STOP, KIND_COUNT, KIND_CLEAR, KIND_CAPTURE: begin
        if (roll < 85)      b.wv = 32'd1;
        else if (roll < 93) b.wv = 32'd0;
      end
      KIND_CLEAR_EVENT: begin
        if (roll < 80)      b.wv = 32'd0;
        else if (roll < 90) b.wv = 32'd1;
      end
      KIND_WRITE_COMPARE: begin
        if (roll < 60)      b.wv = $urandom_range(0, 40);
        else if (roll < 75) b.wv = $urandom_range(0, 300);
      end
      default: begin
      end
    endcase
    return b;
  endfunction

  // One random phase: drain, reprogram every register, then queue beats.
  task automatic run_phase(input logic mode, input logic [1:0] wsel, input logic [3:0] shift,
                           input logic [3:0] clr, input logic [3:0] stop,
                           input logic [3:0] ien, input int n, input bit step_heavy);
    wait_drained();
    repeat (4) @(posedge clk);
    write_reg(REG_COUNTER_MODE, {3'd0, mode});
    write_reg(REG_WIDTH_SELECT, {2'd0, wsel});
    write_reg(REG_PRESCALE_SHIFT, shift);
    write_reg(REG_CLEAR_ON_COMPARE, clr);
    write_reg(REG_STOP_ON_COMPARE, stop);
    write_reg(REG_IRQ_ENABLE, ien);
    if (mode == MODE_TIMER) begin
      push_beat(KIND_START, 2'd0, 32'd1);
    end
    repeat (n) stim_q.push_back(random_beat(step_heavy, mode));
  endtask

  initial begin
    cnt_q     = '0;
    cmp_q     = '{default: '0};
    evt_q     = '0;
    running_q = 1'b0;
    presc_q   = '0;
    mode_r    = MODE_TIMER;
    wsel_r    = WIDTH_16;
    shift_r   = '0;
    clr_r     = '0;
    stop_r    = '0;
    ien_r     = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset configuration: timer mode, 16 bits, no prescale, nothing enabled.
    push_beat(KIND_READ_COMPARE, 2'd0, 32'd0);
    push_beat(KIND_WRITE_COMPARE, 2'd0, 32'd3);
    push_beat(KIND_WRITE_COMPARE, 2'd1, 32'hFFFF_FFFF);
    push_beat(KIND_READ_COMPARE, 2'd1, 32'd0);
    push_beat(KIND_START, 2'd0, 32'd1);
    repeat (4) push_beat(KIND_TICK, 2'd0, 32'd0);
    push_beat(KIND_READ_EVENT, 2'd0, 32'd0);
    push_beat(KIND_CLEAR_EVENT, 2'd0, 32'd1);
    push_beat(KIND_CLEAR_EVENT, 2'd0, 32'd0);
    push_beat(KIND_CAPTURE, 2'd2, 32'd1);
    push_beat(KIND_START, 2'd0, 32'd2);
    push_beat(KIND_STOP, 2'd0, 32'd1);
    push_beat(KIND_TICK, 2'd3, 32'hFFFF_FFFF);
    push_beat(KIND_COUNT, 2'd0, 32'd1);
    push_beat(KIND_TOP, 2'd3, 32'd1);
    push_beat(KIND_CLEAR, 2'd0, 32'd1);
    push_beat(KIND_READ_COMPARE, 2'd2, 32'd0);
    push_beat(KIND_WRITE_COMPARE, 2'd3, 32'h1234_5678);

    // Counter mode, 8 bits: a match clears the counter; start is ignored here.
    wait_drained();
    repeat (4) @(posedge clk);
    write_reg(REG_COUNTER_MODE, {3'd0, MODE_COUNTER});
    write_reg(REG_WIDTH_SELECT, {2'd0, WIDTH_8});
    write_reg(REG_CLEAR_ON_COMPARE, 4'hF);
    write_reg(REG_STOP_ON_COMPARE, 4'hF);
    write_reg(REG_IRQ_ENABLE, 4'hF);
    push_beat(KIND_WRITE_COMPARE, 2'd0, 32'd2);
    repeat (3) push_beat(KIND_COUNT, 2'd1, 32'd1);
    push_beat(KIND_READ_EVENT, 2'd0, 32'd0);
    push_beat(KIND_START, 2'd0, 32'd1);

    // Random phases over a spread of settings, extremes first.
    run_phase(MODE_TIMER, WIDTH_8, 4'd0, 4'h0, 4'h0, 4'hF, 300, 1'b1);
    run_phase(MODE_TIMER, WIDTH_16, 4'd2, 4'h5, 4'h2, 4'h3, 100, 1'b0);
    run_phase(MODE_COUNTER, WIDTH_8, 4'd15, 4'hA, 4'hF, 4'h0, 100, 1'b1);
    run_phase(MODE_TIMER, WIDTH_32, 4'd15, 4'hF, 4'h0, 4'h8, 60, 1'b0);
    run_phase(MODE_TIMER, WIDTH_24, 4'd1, 4'($urandom), 4'($urandom), 4'($urandom),
              100, 1'b0);
    run_phase(MODE_COUNTER, WIDTH_32, 4'($urandom), 4'($urandom), 4'($urandom),
              4'($urandom), 100, 1'b0);
    run_phase(1'($urandom), 2'($urandom), 4'($urandom_range(0, 3)), 4'($urandom),
              4'($urandom), 4'($urandom), 100, 1'($urandom));

    wait_drained();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
